// File: hw/rtl/least_loaded_job_assigner_defines.svh
// Assertion macros shared by the least-loaded job assigner RTL.
// No dependencies; included by files that carry assertions.
`ifndef LEAST_LOADED_JOB_ASSIGNER_DEFINES_SVH
`define LEAST_LOADED_JOB_ASSIGNER_DEFINES_SVH

// same-cycle implication
`define LLJA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LLJA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/llja_pkg.sv
// Shared constants, types and helpers for the least-loaded job assigner.
// No dependencies.
package llja_pkg;

   localparam int MAX_MACHINES = 8;
   localparam int MAX_SLOTS    = 16;

   localparam int MACH_W = $clog2(MAX_MACHINES);
   localparam int JOBS_W = $clog2(MAX_MACHINES + 1);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SLOT_W = 4;
   localparam int LOAD_W = 32;
   localparam int TIME_W = 16;
   localparam int ID_W   = 16;
   localparam int NUM_W  = 4;

   localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(8);

   typedef struct packed {
      logic              valid;
      logic [LOAD_W-1:0] load;
      logic [MACH_W-1:0] idx;
   } node_type;

   typedef struct packed {
      logic [MACH_W-1:0] machine;
      logic [SLOT_W-1:0] slot;
      logic [LOAD_W-1:0] load;
      logic              full;
   } assign_type;

   function automatic logic [JOBS_W-1:0] machines_in_use(input logic [NUM_W-1:0] n);
      logic [JOBS_W-1:0] m;
      if (n == '0) begin
         m = JOBS_W'(1);
      end else if (32'(n) > MAX_MACHINES) begin
         m = JOBS_W'(MAX_MACHINES);
      end else begin
         m = JOBS_W'(n);
      end
      return m;
   endfunction

endpackage

// File: hw/rtl/llja_min_search.sv
// Compare tree picking the least-loaded machine among those in use.
// Depends on llja_pkg.
module llja_min_search
   import llja_pkg::*;
(
   input  logic [LOAD_W-1:0] loads [MAX_MACHINES],
   input  logic [JOBS_W-1:0] in_use,
   output logic [MACH_W-1:0] best
);

   localparam int LEAVES = 1 << MACH_W;

   node_type tree [2*LEAVES];

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < MAX_MACHINES) begin
            tree[LEAVES+i].valid = (JOBS_W'(i) < in_use);
            tree[LEAVES+i].load  = loads[i];
         end else begin
            tree[LEAVES+i].valid = 1'b0;
            tree[LEAVES+i].load  = '0;
         end
         tree[LEAVES+i].idx = MACH_W'(i);
      end
      // left child holds lower indices: ties go left
      for (int n = LEAVES - 1; n >= 1; n--) begin
         if (tree[2*n].valid && (!tree[2*n+1].valid || tree[2*n].load <= tree[2*n+1].load)) begin
            tree[n] = tree[2*n];
         end else begin
            tree[n] = tree[2*n+1];
         end
      end
      tree[0] = '0;
   end

   assign best = tree[1].idx;

endmodule

// File: hw/rtl/llja_sched_core.sv
// Machine load and slot tables, job counter and per-item assignment logic.
// Depends on llja_pkg, llja_min_search and least_loaded_job_assigner_defines.svh.
`include "least_loaded_job_assigner_defines.svh"
module llja_sched_core
   import llja_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              upd_en,
   input  logic              first,
   input  logic [TIME_W-1:0] job_time,
   input  logic [NUM_W-1:0]  num_machines,
   output assign_type        result
);

   logic [LOAD_W-1:0] load_ff [MAX_MACHINES];
   logic [CNT_W-1:0]  cnt_ff  [MAX_MACHINES];
   logic [JOBS_W-1:0] jobs_seen_ff;

   logic [LOAD_W-1:0] load_in;
   logic [CNT_W-1:0]  cnt_in;
   logic [JOBS_W-1:0] jobs_seen_in;

   logic [JOBS_W-1:0] in_use;
   logic [JOBS_W-1:0] eff_seen;
   logic [MACH_W-1:0] best;
   logic [MACH_W-1:0] mach;
   logic [LOAD_W-1:0] cur_load;
   logic [CNT_W-1:0]  cur_cnt;
   logic [LOAD_W:0]   sum_wide;

   assign in_use = machines_in_use(num_machines);

   llja_min_search u_min_search (
      .loads  (load_ff),
      .in_use (in_use),
      .best   (best)
   );

   always_comb begin
      eff_seen = first ? '0 : jobs_seen_ff;
      if (eff_seen < in_use) begin
         mach         = eff_seen[MACH_W-1:0];
         jobs_seen_in = eff_seen + JOBS_W'(1);
      end else begin
         mach         = best;
         jobs_seen_in = eff_seen;
      end

      cur_load = first ? '0 : load_ff[mach];
      cur_cnt  = first ? '0 : cnt_ff[mach];

      sum_wide = {1'b0, cur_load} + (LOAD_W+1)'(job_time);
      load_in  = sum_wide[LOAD_W] ? '1 : sum_wide[LOAD_W-1:0];

      result.machine = mach;
      result.load    = load_in;
      if (cur_cnt >= CNT_W'(MAX_SLOTS)) begin
         result.slot = SLOT_W'(MAX_SLOTS - 1);
         result.full = 1'b1;
         cnt_in      = cur_cnt;
      end else begin
         result.slot = SLOT_W'(cur_cnt);
         result.full = 1'b0;
         cnt_in      = cur_cnt + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jobs_seen_ff <= '0;
         for (int i = 0; i < MAX_MACHINES; i++) begin
            load_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (upd_en) begin
         jobs_seen_ff <= jobs_seen_in;
         for (int i = 0; i < MAX_MACHINES; i++) begin
            if (MACH_W'(i) == mach) begin
               load_ff[i] <= load_in;
               cnt_ff[i]  <= cnt_in;
            end else if (first) begin
               load_ff[i] <= '0;
               cnt_ff[i]  <= '0;
            end
         end
      end
   end

   `LLJA_ASSERT_NOW(a_seen_bound, clock, reset, 1'b1, jobs_seen_ff <= JOBS_W'(MAX_MACHINES), "job counter out of range")
   `LLJA_ASSERT_NOW(a_mach_in_use, clock, reset, upd_en, JOBS_W'(mach) < in_use, "machine outside active set")
   `LLJA_ASSERT_NEXT(a_first_restart, clock, reset, upd_en && first, jobs_seen_ff == JOBS_W'(1), "new schedule did not restart counter")

endmodule

// File: hw/rtl/least_loaded_job_assigner.sv
// Least-loaded job assigner: greedy list scheduler over up to eight machines.
// Input channel req_*, result channel rsp_* (valid/ready), config port csr_*.
// Each accepted item yields one result: machine, slot, echoed id, new load and
// a full flag. An item with req_first_job set starts a new schedule by clearing
// all loads, slot counts and the job counter first.
// Each accepted item passes through the input register, then the result register,
// where its result is presented until it is taken.
// Throughput: one item per cycle while rsp_ready stays high.
// The cycle is set by the eight-way load compare tree followed by the 32-bit
// saturating add, all between the input and result registers.
// Reset (synchronous, active high) clears all tables, the job counter and both
// valid flags, and sets the machine count to 8.
// When rsp_ready is low the result register holds; one more item can wait in
// the input register, after which req_ready drops until the result is taken.
// csr_write_data is to be written by the user only while the block is idle; the block does not enforce it.
`include "least_loaded_job_assigner_defines.svh"
module least_loaded_job_assigner
   import llja_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_first_job,
   input  logic [ID_W-1:0]   req_job_id,
   input  logic [TIME_W-1:0] req_job_time,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [MACH_W-1:0] rsp_machine,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [ID_W-1:0]   rsp_assigned_id,
   output logic [LOAD_W-1:0] rsp_machine_load,
   output logic              rsp_slots_full,

   input  logic              csr_write_enable,
   input  logic [NUM_W-1:0]  csr_write_data
);

   logic              in_valid_ff, in_valid_in;
   logic              in_first_ff;
   logic [ID_W-1:0]   in_id_ff;
   logic [TIME_W-1:0] in_time_ff;

   logic              out_valid_ff, out_valid_in;
   assign_type        out_res_ff;
   logic [ID_W-1:0]   out_id_ff;

   logic [NUM_W-1:0]  num_ff;

   logic              advance;
   logic              req_accept;
   assign_type        result;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   llja_sched_core u_core (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (advance),
      .first        (in_first_ff),
      .job_time     (in_time_ff),
      .num_machines (num_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         num_ff       <= NUM_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            num_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_first_ff <= req_first_job;
         in_id_ff    <= req_job_id;
         in_time_ff  <= req_job_time;
      end
      if (advance) begin
         out_res_ff <= result;
         out_id_ff  <= in_id_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_machine      = out_res_ff.machine;
   assign rsp_slot         = out_res_ff.slot;
   assign rsp_assigned_id  = out_id_ff;
   assign rsp_machine_load = out_res_ff.load;
   assign rsp_slots_full   = out_res_ff.full;

   `LLJA_ASSERT_NEXT(a_advance_shows, clock, reset, advance, out_valid_ff, "advanced item not presented")
   `LLJA_ASSERT_NOW(a_full_slot, clock, reset, out_valid_ff && out_res_ff.full, out_res_ff.slot == SLOT_W'(MAX_SLOTS - 1), "full flag without last slot")

endmodule
